>>> src/rmfw_pkg.sv
package rmfw_pkg;

  localparam int unsigned NUM_THREADS = 16;
  localparam int unsigned COUNT_WIDTH = 8;

  // fixed field widths of the request and response
  localparam int unsigned CmdWidth       = 1;
  localparam int unsigned TidWidth       = 4;
  localparam int unsigned StatusWidth    = 4;
  localparam int unsigned HoldCountWidth = 8;

  localparam int unsigned PtrWidth  = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
  localparam int unsigned FillWidth = $clog2(NUM_THREADS + 1);

  localparam logic [COUNT_WIDTH-1:0] CountLimit = {COUNT_WIDTH{1'b1}};

  // commands
  localparam logic [CmdWidth-1:0] CMD_ACQUIRE = 1'b0;
  localparam logic [CmdWidth-1:0] CMD_RELEASE = 1'b1;

  // response status codes
  localparam logic [StatusWidth-1:0] ST_GRANTED         = 4'd0;
  localparam logic [StatusWidth-1:0] ST_REGRANTED       = 4'd1;
  localparam logic [StatusWidth-1:0] ST_QUEUED          = 4'd2;
  localparam logic [StatusWidth-1:0] ST_PARTIAL         = 4'd3;
  localparam logic [StatusWidth-1:0] ST_FREED           = 4'd4;
  localparam logic [StatusWidth-1:0] ST_HANDED          = 4'd5;
  localparam logic [StatusWidth-1:0] ST_NOT_HOLDER      = 4'd6;
  localparam logic [StatusWidth-1:0] ST_ALREADY_WAITING = 4'd7;
  localparam logic [StatusWidth-1:0] ST_OVERFLOW        = 4'd8;

  typedef struct packed {
    logic                   held;
    logic [TidWidth-1:0]    holder;
    logic [COUNT_WIDTH-1:0] count;
    logic [PtrWidth-1:0]    head;
    logic [PtrWidth-1:0]    tail;
    logic [FillWidth-1:0]   fill;
    logic [NUM_THREADS-1:0] waiting;
  } lock_state_t;

  typedef struct packed {
    logic                      we;
    logic [PtrWidth-1:0]       waddr;
    logic [TidWidth-1:0]       wdata;
  } ring_wr_t;

  typedef struct packed {
    logic [StatusWidth-1:0]    status;
    logic                      woken_valid;
    logic [TidWidth-1:0]       woken_thread;
    logic [HoldCountWidth-1:0] hold_count;
  } rsp_t;

  function automatic logic [PtrWidth-1:0] ring_next(input logic [PtrWidth-1:0] p);
    logic [PtrWidth-1:0] r;
    if (p == PtrWidth'(NUM_THREADS - 1)) r = '0;
    else r = p + PtrWidth'(1);
    return r;
  endfunction

endpackage

>>> src/rmfw_if.sv
interface rmfw_req_if;
  logic                              valid;
  logic                              ready;
  logic [rmfw_pkg::CmdWidth-1:0]     command;
  logic [rmfw_pkg::TidWidth-1:0]     thread_id;

  modport source (output valid, output command, output thread_id, input ready);
  modport sink   (input valid, input command, input thread_id, output ready);
endinterface

interface rmfw_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic [rmfw_pkg::StatusWidth-1:0]      status;
  logic                                  woken_valid;
  logic [rmfw_pkg::TidWidth-1:0]         woken_thread;
  logic [rmfw_pkg::HoldCountWidth-1:0]   hold_count;

  modport source (output valid, output status, output woken_valid, output woken_thread,
                  output hold_count, input ready);
  modport sink   (input valid, input status, input woken_valid, input woken_thread,
                  input hold_count, output ready);
endinterface

>>> src/recursive_mutex_with_fifo_waiters.sv
// recursive lock with a first-in first-out wait queue
//
// req_i carries one request per handshake: command (0 acquire, 1 release)
// and thread_id. rsp_o returns exactly one response per request, in order:
// status, woken_valid/woken_thread (set when the lock was handed to the
// oldest waiter) and the holder's hold_count after the request.
//
// each request takes an accept cycle, then an execute cycle in which the
// wait ring entry at the queue head, read from the registered output of
// the ring ram, is available and the new lock state, ring write and
// response are committed together. a new request is accepted only once
// the previous one has committed.
//
// the response sits in an output register, so a new request is accepted
// while the previous response still waits. if the receiver stalls and the
// output register is full, the execute cycle holds until it drains.
//
// reset (rst_ni low, asynchronous) frees the lock, empties the queue and
// clears the waiting mask; the ring ram itself needs no clearing.
module recursive_mutex_with_fifo_waiters (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmfw_req_if.sink   req_i,
  rmfw_rsp_if.source rsp_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic fsm_q, fsm_d;

  // latched request
  logic [rmfw_pkg::CmdWidth-1:0] cmd_q;
  logic [rmfw_pkg::TidWidth-1:0] tid_q;

  // architectural lock state
  rmfw_pkg::lock_state_t lock_q, lock_d;

  // output register
  logic           out_valid_q, out_valid_d;
  rmfw_pkg::rsp_t out_q;

  rmfw_pkg::rsp_t   core_rsp;
  rmfw_pkg::ring_wr_t ring_wr;
  logic [rmfw_pkg::TidWidth-1:0] head_tid;

  logic accept;
  logic commit;

  assign req_i.ready = (fsm_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // execute completes only when the output register can take the response
  assign commit = (fsm_q == S_EXEC) && (!out_valid_q || rsp_o.ready);

  // ring ram read address follows the head; data is valid in the execute cycle
  // since the head only moves on commit and the state returns to idle after
  rmfw_ram #(
    .Width (rmfw_pkg::TidWidth),
    .Depth (rmfw_pkg::NUM_THREADS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_wr.we && commit),
    .waddr_i (ring_wr.waddr),
    .wdata_i (ring_wr.wdata),
    .raddr_i (lock_q.head),
    .rdata_o (head_tid)
  );

  rmfw_core u_core (
    .command_i   (cmd_q),
    .thread_id_i (tid_q),
    .state_i     (lock_q),
    .head_tid_i  (head_tid),
    .state_o     (lock_d),
    .ring_wr_o   (ring_wr),
    .rsp_o       (core_rsp)
  );

  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      S_IDLE: begin
        if (accept) fsm_d = S_EXEC;
      end
      S_EXEC: begin
        if (commit) fsm_d = S_IDLE;
      end
      default: fsm_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= S_IDLE;
      out_valid_q <= 1'b0;
      lock_q      <= '0;
    end else begin
      fsm_q       <= fsm_d;
      out_valid_q <= out_valid_d;
      if (commit) begin
        lock_q <= lock_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= req_i.command;
      tid_q <= req_i.thread_id;
    end
    if (commit) begin
      out_q <= core_rsp;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.woken_valid  = out_q.woken_valid;
  assign rsp_o.woken_thread = out_q.woken_thread;
  assign rsp_o.hold_count   = out_q.hold_count;

endmodule

>>> src/rmfw_ram.sv
module rmfw_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  waddr_i,
  input  logic [Width-1:0]                              wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  raddr_i,
  output logic [Width-1:0]                              rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/rmfw_core.sv
module rmfw_core (
  input  logic [rmfw_pkg::CmdWidth-1:0] command_i,
  input  logic [rmfw_pkg::TidWidth-1:0] thread_id_i,
  input  rmfw_pkg::lock_state_t         state_i,
  input  logic [rmfw_pkg::TidWidth-1:0] head_tid_i,
  output rmfw_pkg::lock_state_t         state_o,
  output rmfw_pkg::ring_wr_t            ring_wr_o,
  output rmfw_pkg::rsp_t                rsp_o
);

  logic                                 tid_ok;
  logic                                 is_holder;
  logic [rmfw_pkg::COUNT_WIDTH-1:0]     count_dec;
  logic [rmfw_pkg::TidWidth-1:0]        woken;

  assign tid_ok    = (32'(thread_id_i) < 32'(rmfw_pkg::NUM_THREADS));
  assign is_holder = state_i.held && (state_i.holder == thread_id_i);
  assign count_dec = state_i.count - rmfw_pkg::COUNT_WIDTH'(1);

  always_comb begin
    state_o    = state_i;
    ring_wr_o  = '0;
    woken      = '0;
    rsp_o      = '0;
    rsp_o.status = rmfw_pkg::ST_NOT_HOLDER;
    ring_wr_o.waddr = state_i.tail;
    ring_wr_o.wdata = thread_id_i;

    if (tid_ok) begin
      if (command_i == rmfw_pkg::CMD_ACQUIRE) begin
        if (is_holder) begin
          if (state_i.count == rmfw_pkg::CountLimit) begin
            rsp_o.status = rmfw_pkg::ST_OVERFLOW;
          end else begin
            state_o.count = state_i.count + rmfw_pkg::COUNT_WIDTH'(1);
            rsp_o.status  = rmfw_pkg::ST_REGRANTED;
          end
        end else if (!state_i.held) begin
          state_o.held   = 1'b1;
          state_o.holder = thread_id_i;
          state_o.count  = rmfw_pkg::COUNT_WIDTH'(1);
          rsp_o.status   = rmfw_pkg::ST_GRANTED;
        end else if (state_i.waiting[thread_id_i] ||
                     (state_i.fill >= rmfw_pkg::FillWidth'(rmfw_pkg::NUM_THREADS))) begin
          rsp_o.status = rmfw_pkg::ST_ALREADY_WAITING;
        end else begin
          // join the tail of the wait ring
          ring_wr_o.we                 = 1'b1;
          state_o.tail                 = rmfw_pkg::ring_next(state_i.tail);
          state_o.fill                 = state_i.fill + rmfw_pkg::FillWidth'(1);
          state_o.waiting[thread_id_i] = 1'b1;
          rsp_o.status                 = rmfw_pkg::ST_QUEUED;
        end
      end else if (is_holder) begin
        if (count_dec != '0) begin
          state_o.count = count_dec;
          rsp_o.status  = rmfw_pkg::ST_PARTIAL;
        end else if (state_i.fill != '0) begin
          // hand the lock straight to the oldest waiter
          woken                  = head_tid_i;
          state_o.head           = rmfw_pkg::ring_next(state_i.head);
          state_o.fill           = state_i.fill - rmfw_pkg::FillWidth'(1);
          state_o.waiting[woken] = 1'b0;
          state_o.holder         = woken;
          state_o.count          = rmfw_pkg::COUNT_WIDTH'(1);
          rsp_o.woken_valid      = 1'b1;
          rsp_o.status           = rmfw_pkg::ST_HANDED;
        end else begin
          state_o.held   = 1'b0;
          state_o.holder = '0;
          state_o.count  = '0;
          rsp_o.status   = rmfw_pkg::ST_FREED;
        end
      end
    end

    rsp_o.woken_thread = woken;
    rsp_o.hold_count   = state_o.held ? rmfw_pkg::HoldCountWidth'(state_o.count) : '0;
  end

endmodule
